@@ src/bdr_pkg.sv @@
// ----------------------------------------------------------------------------
// bdr_pkg
// shared constants and types for the barycentric depth test raster core
// ----------------------------------------------------------------------------
package bdr_pkg;

  localparam int SCREEN_W   = 1366;
  localparam int SCREEN_H   = 768;
  localparam int STORE_SIZE = SCREEN_W * SCREEN_H;
  localparam int ADDR_W     = $clog2(STORE_SIZE);

  localparam logic signed [15:0] DEPTH_MIN = 16'sh8000;
  localparam logic signed [15:0] DEPTH_MAX = 16'sh7fff;

  localparam logic ACT_TEST  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam int DIV_BITS = 16;
  localparam int STG_DIV0 = 6;
  localparam int STG_RD   = STG_DIV0 + DIV_BITS + 1;
  localparam int STG_FIN  = STG_RD + 1;
  localparam int NSTG     = STG_FIN + 1;

  typedef struct packed {
    logic              act;
    logic [10:0]       px;
    logic [9:0]        py;
    logic              on;
    logic [ADDR_W-1:0] addr;
    logic              hit;
  } side_t;

endpackage

@@ src/barycentric_depth_test_raster_core.sv @@
// ----------------------------------------------------------------------------
// barycentric_depth_test_raster_core
// edge weight coverage test, interpolated depth and depth buffer update
// ----------------------------------------------------------------------------
// One transaction is accepted per clock while the output is not stalled and
// gives one result; the pipeline length is set by the 16-stage restoring divider
// that forms the depth quotient and by the registered depth memory read ahead
// of the compare and write back. The whole pipeline stalls while a result waits
// at the output. Depth entries are undefined until a clear transaction writes them.
module barycentric_depth_test_raster_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // v0x, v0y, v1x, v1y, v2x, v2y, z0, z1, z2, pixel_x, pixel_y, zero pad
  input  logic [135:0] in_tdata,
  // action
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_depth, out_shade, zero pad
  output logic [47:0]  out_tdata,
  // covered, written
  output logic [1:0]   out_tuser
);

  localparam int NS = bdr_pkg::NSTG;
  localparam int DB = bdr_pkg::DIV_BITS;

  logic adv;
  logic in_fire;
  logic [7:0] shade_r;
  logic [NS-1:0] v_r;
  bdr_pkg::side_t side_r [NS];
  bdr_pkg::side_t side_in;
  bdr_pkg::side_t side3_c;

  logic [10:0] x0, x1, x2, px;
  logic [9:0]  y0, y1, y2, py;
  logic signed [15:0] z0, z1, z2;

  logic signed [11:0] a_r, c_r, dx_r;
  logic signed [10:0] b_r, d_r, dy_r;
  logic signed [15:0] z0_r [4], z1_r [4], z2_r [4];
  logic signed [22:0] pab_r, pcd_r, pcdy_r, pdxb_r, pdxd_r, pady_r;
  logic signed [23:0] area_r, w1_r, w2_r;
  logic signed [25:0] w0_c;
  logic signed [25:0] w0_r, w1x_r, w2x_r;
  logic signed [23:0] ar4_r, ar5_r, ar6_r;
  logic               inside_c;
  logic signed [41:0] m0_r, m1_r, m2_r;
  logic signed [43:0] num_r;

  logic [39:0] rem_r [DB+1];
  logic [DB-1:0] quo_r [DB+1];
  logic [21:0] dab_r [DB+1];
  logic        neg_r [DB+1];

  logic signed [16:0] q_c;
  logic signed [15:0] dep_c, dep_r, dep_f_r;
  logic signed [15:0] rd_q_r;
  logic signed [15:0] stored_c;
  logic        pass_c, we_c;
  logic signed [15:0] wd_c;
  logic        fwd_v_r;
  logic [bdr_pkg::ADDR_W-1:0] fwd_a_r;
  logic signed [15:0] fwd_d_r;
  logic signed [15:0] mem [bdr_pkg::STORE_SIZE];

  logic        out_valid_r, out_cov_r, out_wr_r;
  logic [10:0] out_x_r;
  logic [9:0]  out_y_r;
  logic signed [15:0] out_dep_r;
  logic [7:0]  out_shade_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign in_fire   = in_tvalid && adv;

  assign x0 = in_tdata[10:0];
  assign y0 = in_tdata[20:11];
  assign x1 = in_tdata[31:21];
  assign y1 = in_tdata[41:32];
  assign x2 = in_tdata[52:42];
  assign y2 = in_tdata[62:53];
  assign z0 = in_tdata[78:63];
  assign z1 = in_tdata[94:79];
  assign z2 = in_tdata[110:95];
  assign px = in_tdata[121:111];
  assign py = in_tdata[131:122];

  always_comb begin
    side_in.act    = in_tuser;
    side_in.px     = px;
    side_in.py     = py;
    side_in.on     = (32'(px) < 32'(bdr_pkg::SCREEN_W)) && (32'(py) < 32'(bdr_pkg::SCREEN_H));
    side_in.addr   = bdr_pkg::ADDR_W'(py) * bdr_pkg::ADDR_W'(bdr_pkg::SCREEN_W)
                     + bdr_pkg::ADDR_W'(px);
    side_in.hit    = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shade_r <= '0;
    end else if (cfg_we) begin
      shade_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], in_fire};
    end
  end

  // edge weights
  always_comb begin
    w0_c = 26'(area_r) - 26'(w1_r) - 26'(w2_r);
    if (area_r > 24'sd0) begin
      inside_c = !w0_c[25] && !w1_r[23] && !w2_r[23];
    end else if (area_r < 24'sd0) begin
      inside_c = (w0_c <= 26'sd0) && (w1_r <= 24'sd0) && (w2_r <= 24'sd0);
    end else begin
      inside_c = 1'b0;
    end
    side3_c     = side_r[2];
    side3_c.hit = inside_c;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_in;
      for (int i = 1; i < NS; i++) begin
        if (i != 3) begin
          side_r[i] <= side_r[i-1];
        end
      end
      side_r[3] <= side3_c;

      a_r  <= $signed({1'b0, x1}) - $signed({1'b0, x0});
      c_r  <= $signed({1'b0, x2}) - $signed({1'b0, x0});
      dx_r <= $signed({1'b0, x0}) - $signed({1'b0, px});
      b_r  <= $signed({1'b0, y2}) - $signed({1'b0, y0});
      d_r  <= $signed({1'b0, y1}) - $signed({1'b0, y0});
      dy_r <= $signed({1'b0, y0}) - $signed({1'b0, py});
      z0_r[0] <= z0;
      z1_r[0] <= z1;
      z2_r[0] <= z2;
      for (int i = 1; i < 4; i++) begin
        z0_r[i] <= z0_r[i-1];
        z1_r[i] <= z1_r[i-1];
        z2_r[i] <= z2_r[i-1];
      end

      pab_r  <= a_r * b_r;
      pcd_r  <= c_r * d_r;
      pcdy_r <= c_r * dy_r;
      pdxb_r <= dx_r * b_r;
      pdxd_r <= dx_r * d_r;
      pady_r <= a_r * dy_r;

      area_r <= 24'(pab_r) - 24'(pcd_r);
      w1_r   <= 24'(pcdy_r) - 24'(pdxb_r);
      w2_r   <= 24'(pdxd_r) - 24'(pady_r);

      w0_r  <= w0_c;
      w1x_r <= 26'(w1_r);
      w2x_r <= 26'(w2_r);
      ar4_r <= area_r;

      m0_r  <= w0_r * z0_r[3];
      m1_r  <= w1x_r * z1_r[3];
      m2_r  <= w2x_r * z2_r[3];
      ar5_r <= ar4_r;

      num_r <= 44'(m0_r) + 44'(m1_r) + 44'(m2_r);
      ar6_r <= ar5_r;

      rem_r[0] <= num_r[43] ? 40'(-num_r) : 40'(num_r);
      quo_r[0] <= '0;
      dab_r[0] <= ar6_r[23] ? 22'(-ar6_r) : 22'(ar6_r);
      neg_r[0] <= num_r[43] ^ ar6_r[23];

      // restoring divider, one quotient bit per stage
      for (int k = 0; k < DB; k++) begin
        dab_r[k+1] <= dab_r[k];
        neg_r[k+1] <= neg_r[k];
        if (rem_r[k] >= (40'(dab_r[k]) << (DB - 1 - k))) begin
          rem_r[k+1] <= rem_r[k] - (40'(dab_r[k]) << (DB - 1 - k));
          quo_r[k+1] <= quo_r[k] | DB'(1 << (DB - 1 - k));
        end else begin
          rem_r[k+1] <= rem_r[k];
          quo_r[k+1] <= quo_r[k];
        end
      end

      dep_r   <= dep_c;
      dep_f_r <= dep_r;
    end
  end

  always_comb begin
    q_c = neg_r[DB] ? -$signed({1'b0, quo_r[DB]}) : $signed({1'b0, quo_r[DB]});
    if (side_r[bdr_pkg::STG_RD-1].act == bdr_pkg::ACT_CLEAR) begin
      dep_c = bdr_pkg::DEPTH_MIN;
    end else if (!side_r[bdr_pkg::STG_RD-1].hit) begin
      dep_c = '0;
    end else if (q_c > 17'(bdr_pkg::DEPTH_MAX)) begin
      dep_c = bdr_pkg::DEPTH_MAX;
    end else begin
      dep_c = 16'(q_c);
    end
  end

  // depth compare with forwarding of the previous write
  always_comb begin
    stored_c = (fwd_v_r && fwd_a_r == side_r[bdr_pkg::STG_FIN].addr) ? fwd_d_r : rd_q_r;
    pass_c   = (side_r[bdr_pkg::STG_FIN].act == bdr_pkg::ACT_TEST)
               && side_r[bdr_pkg::STG_FIN].hit && (stored_c < dep_f_r);
    we_c     = v_r[bdr_pkg::STG_FIN] && side_r[bdr_pkg::STG_FIN].on
               && ((side_r[bdr_pkg::STG_FIN].act == bdr_pkg::ACT_CLEAR) || pass_c);
    wd_c     = dep_f_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (we_c) begin
        mem[side_r[bdr_pkg::STG_FIN].addr] <= wd_c;
      end
      rd_q_r <= mem[side_r[bdr_pkg::STG_RD].addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      fwd_v_r     <= we_c;
      out_valid_r <= v_r[bdr_pkg::STG_FIN];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_a_r     <= side_r[bdr_pkg::STG_FIN].addr;
      fwd_d_r     <= wd_c;
      out_cov_r   <= (side_r[bdr_pkg::STG_FIN].act == bdr_pkg::ACT_TEST)
                     && side_r[bdr_pkg::STG_FIN].hit;
      out_wr_r    <= pass_c && side_r[bdr_pkg::STG_FIN].on;
      out_x_r     <= side_r[bdr_pkg::STG_FIN].px;
      out_y_r     <= side_r[bdr_pkg::STG_FIN].py;
      out_dep_r   <= dep_f_r;
      out_shade_r <= (pass_c && side_r[bdr_pkg::STG_FIN].on) ? shade_r : 8'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_shade_r, out_dep_r, out_y_r, out_x_r};
  assign out_tuser  = {out_wr_r, out_cov_r};

  a_wr_cov: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cov_r || !out_wr_r))
    else $error("written without coverage");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_dep_r)))
    else $error("result lost during stall");

  a_we_on: assert property (@(posedge clk) disable iff (!rst_n)
    we_c |-> (side_r[bdr_pkg::STG_FIN].on && adv == in_tready))
    else $error("depth write off screen");

endmodule

@@ verif/barycentric_depth_test_raster_core_tb.sv @@
// ----------------------------------------------------------------------------
// barycentric_depth_test_raster_core_tb
// self-checking bench for the triangle coverage and depth buffer core
// ----------------------------------------------------------------------------
// A queue of pixel transactions feeds a bursty stream driver. Every accepted
// transaction is run through a behavioral coverage, interpolation and depth
// buffer predictor. The monitor checks each result against the oldest
// prediction while the receiver stalls at random. Several shade settings are
// used. Tested pixels are always cleared first, so that no undefined depth
// entry is ever read.
// ----------------------------------------------------------------------------
module barycentric_depth_test_raster_core_tb;

  typedef struct {
    logic         act;
    logic [135:0] data;
  } pix_txn_t;

  typedef struct {
    logic        covered;
    logic        written;
    logic [10:0] x;
    logic [9:0]  y;
    logic [15:0] depth;
    logic [7:0]  shade;
  } pix_result_t;

  localparam int POOL_N = 40;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [7:0]   cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;
  logic [1:0]   out_tuser;

  pix_txn_t     pend_q[$];
  pix_result_t  result_q[$];
  logic [15:0]  zbuf_model[int];
  logic [7:0]   shade_model = '0;
  int           pool_x[POOL_N];
  int           pool_y[POOL_N];
  int           mismatch_cnt = 0;
  bit           hold_tx = 1'b0;
  bit           long_stall_req = 1'b0;
  pix_txn_t     cur;
  int           burst_left = 0;
  int           gap_left = 0;
  int           long_cnt = 0;
  int           mode_cnt = 0;
  bit           stall_mode = 1'b0;

  barycentric_depth_test_raster_core u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic pix_txn_t make_txn(logic act, int x0, int y0, int x1, int y1,
                                         int x2, int y2, int z0, int z1, int z2,
                                         int px, int py);
    pix_txn_t t;
    t.act  = act;
    t.data = {4'b0, py[9:0], px[10:0], z2[15:0], z1[15:0], z0[15:0],
              y2[9:0], x2[10:0], y1[9:0], x1[10:0], y0[9:0], x0[10:0]};
    return t;
  endfunction

  function automatic void add_item(pix_txn_t t);
    pend_q = {pend_q, t};
  endfunction

  function automatic pix_result_t rasterize_pixel(pix_txn_t t);
    pix_result_t r;
    longint x0, y0, x1, y1, x2, y2, z0, z1, z2, px, py;
    longint area, w0, w1, w2, dx, dy, q;
    int idx;
    bit on, hit;
    x0 = t.data[10:0];    y0 = t.data[20:11];
    x1 = t.data[31:21];   y1 = t.data[41:32];
    x2 = t.data[52:42];   y2 = t.data[62:53];
    z0 = $signed(t.data[78:63]);
    z1 = $signed(t.data[94:79]);
    z2 = $signed(t.data[110:95]);
    px = t.data[121:111]; py = t.data[131:122];
    on  = px < bdr_pkg::SCREEN_W && py < bdr_pkg::SCREEN_H;
    idx = int'(py * bdr_pkg::SCREEN_W + px);
    r.covered = 1'b0; r.written = 1'b0; r.shade = '0; r.depth = '0;
    r.x = px[10:0]; r.y = py[9:0];
    if (t.act == bdr_pkg::ACT_CLEAR) begin
      r.depth = bdr_pkg::DEPTH_MIN;
      if (on) zbuf_model[idx] = bdr_pkg::DEPTH_MIN;
    end else begin
      dx = x0 - px; dy = y0 - py;
      area = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
      w1 = (x2 - x0) * dy - dx * (y2 - y0);
      w2 = dx * (y1 - y0) - (x1 - x0) * dy;
      w0 = area - w1 - w2;
      hit = 1'b0;
      if (area > 0) hit = w0 >= 0 && w1 >= 0 && w2 >= 0;
      else if (area < 0) hit = w0 <= 0 && w1 <= 0 && w2 <= 0;
      if (hit) begin
        q = (w0 * z0 + w1 * z1 + w2 * z2) / area;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        r.covered = 1'b1;
        r.depth = q[15:0];
        if (on && $signed(zbuf_model.exists(idx) ? zbuf_model[idx] : 16'sd0) < q) begin
          zbuf_model[idx] = q[15:0];
          r.written = 1'b1;
          r.shade = shade_model;
        end
      end
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    bit busy;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        result_q = {result_q, rasterize_pixel(cur)};
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (!hold_tx && pend_q.size() > 0) begin
          cur = pend_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= cur.data;
          in_tuser <= cur.act;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (long_cnt > 0) begin
      long_cnt--;
      out_tready <= 1'b0;
    end else if (long_stall_req) begin
      long_stall_req = 1'b0;
      long_cnt = 300;
      out_tready <= 1'b0;
    end else begin
      if (mode_cnt == 0) begin
        mode_cnt = $urandom_range(50, 250);
        stall_mode = $urandom_range(0, 1);
      end
      mode_cnt--;
      out_tready <= stall_mode ? ($urandom_range(0, 9) > 3) : 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    pix_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected transaction %h", out_tdata);
      end else begin
        e = result_q.pop_front();
        if (out_tuser[0] !== e.covered || out_tuser[1] !== e.written ||
            out_tdata[10:0] !== e.x || out_tdata[20:11] !== e.y ||
            out_tdata[36:21] !== e.depth || out_tdata[44:37] !== e.shade) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"mismatch: exp cov %0b wr %0b x %0d y %0d z %0d sh %0d, ",
                      "got cov %0b wr %0b x %0d y %0d z %0d sh %0d"},
                     e.covered, e.written, e.x, e.y, $signed(e.depth), e.shade,
                     out_tuser[0], out_tuser[1], out_tdata[10:0], out_tdata[20:11],
                     $signed(out_tdata[36:21]), out_tdata[44:37]);
        end
      end
    end
  end

  task automatic drain();
    do @(posedge clk); while (pend_q.size() > 0 || in_tvalid || result_q.size() > 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_shade(int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[7:0];
    shade_model = v[7:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int near(int c, int lim);
    int v;
    v = c + $urandom_range(0, 160) - 80;
    if (v < 0) v = 0;
    if (v > lim) v = lim;
    return v;
  endfunction

  task automatic push_random(int n);
    int k, px, py, sel;
    int vx[3], vy[3];
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      k = $urandom_range(0, POOL_N - 1);
      px = pool_x[k]; py = pool_y[k];
      if (sel < 6) begin
        if ($urandom_range(0, 1)) begin
          px = $urandom_range(bdr_pkg::SCREEN_W, 2047); py = $urandom_range(0, 1023);
        end else begin
          px = $urandom_range(0, 2047); py = $urandom_range(bdr_pkg::SCREEN_H, 1023);
        end
      end
      for (int j = 0; j < 3; j++) begin
        if (sel < 75) begin
          vx[j] = near(px, 2047); vy[j] = near(py, 1023);
        end else begin
          vx[j] = $urandom_range(0, 2047); vy[j] = $urandom_range(0, 1023);
        end
      end
      add_item(make_txn((sel >= 6 && sel < 14) ? bdr_pkg::ACT_CLEAR : bdr_pkg::ACT_TEST,
                        vx[0], vy[0], vx[1], vy[1], vx[2], vy[2],
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), px, py));
    end
  endtask

  initial begin
    pool_x[0] = 0;                     pool_y[0] = 0;
    pool_x[1] = bdr_pkg::SCREEN_W - 1; pool_y[1] = bdr_pkg::SCREEN_H - 1;
    pool_x[2] = 100;                   pool_y[2] = 100;
    for (int i = 3; i < POOL_N; i++) begin
      pool_x[i] = $urandom_range(0, bdr_pkg::SCREEN_W - 1);
      pool_y[i] = $urandom_range(0, bdr_pkg::SCREEN_H - 1);
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    set_shade(0);

    for (int i = 0; i < POOL_N; i++)
      add_item(make_txn(bdr_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                        pool_x[i], pool_y[i]));
    // clear off screen
    add_item(make_txn(bdr_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 2047, 1023));
    // counter-clockwise and clockwise triangles with extreme depths
    add_item(make_txn(bdr_pkg::ACT_TEST, 90, 90, 120, 90, 90, 120, 32767, 32767, 32767,
                      100, 100));
    add_item(make_txn(bdr_pkg::ACT_TEST, 90, 90, 90, 120, 120, 90, 65535, 0, 32768,
                      100, 100));
    // same triangle again fails the depth test
    add_item(make_txn(bdr_pkg::ACT_TEST, 90, 90, 120, 90, 90, 120, 32767, 32767, 32767,
                      100, 100));
    // degenerate triangle
    add_item(make_txn(bdr_pkg::ACT_TEST, 0, 0, 50, 50, 200, 200, 100, 100, 100, 100, 100));
    // pixel on a vertex, first at the lowest depth and then at a higher one
    add_item(make_txn(bdr_pkg::ACT_TEST, 0, 0, 40, 0, 0, 40, 32768, 32768, 32768, 0, 0));
    add_item(make_txn(bdr_pkg::ACT_TEST, 0, 0, 40, 0, 0, 40, 500, 600, 700, 0, 0));
    // not covered
    add_item(make_txn(bdr_pkg::ACT_TEST, 0, 0, 10, 0, 0, 10, 500, 600, 700, 100, 100));
    // out of range vertices, pixel at the far corner
    add_item(make_txn(bdr_pkg::ACT_TEST, 2047, 1023, 1000, 1023, 2047, 0, 16384, 49152, 8000,
                      bdr_pkg::SCREEN_W - 1, bdr_pkg::SCREEN_H - 1));
    // covered pixel off screen
    add_item(make_txn(bdr_pkg::ACT_TEST, 1300, 700, 2047, 700, 1300, 1023, 1000, 2000, 3000,
                      1400, 800));
    drain();

    set_shade(255);
    long_stall_req = 1'b1;
    push_random(200);
    drain();

    set_shade($urandom_range(1, 254));
    push_random(100);
    hold_tx = 1'b1;
    repeat (30) @(posedge clk);
    do @(posedge clk); while (in_tvalid || result_q.size() > 0);
    hold_tx = 1'b0;
    push_random(100);
    drain();

    set_shade(170);
    push_random(250);
    drain();

    if (mismatch_cnt == 0 && result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
src/bdr_pkg.sv
src/barycentric_depth_test_raster_core.sv
verif/barycentric_depth_test_raster_core_tb.sv
